/* design/dirh_pkg.sv */
// Shared constants, trig and arctangent tables, and the bin memory control word.
package dirh_pkg;

  // Histogram geometry
  localparam int HALF_BINS = 180;
  localparam int FULL_BINS = 2 * HALF_BINS;
  localparam int BIN_AW = $clog2(HALF_BINS);
  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(HALF_BINS - 1);
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths
  localparam int DIR_W = 8;
  localparam int MEAN_W = 24;
  localparam int LEN_W = 32;
  localparam int ANGLE_W = 16;
  localparam int TOTAL_W = 32;
  localparam logic [DIR_W-1:0] DIR_SPAN = DIR_W'(180);

  // Trig format
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Series term divisors (2j)(2j+1) for j = 1..8
  localparam logic [7:0][63:0] SERIES_DIV = {
    64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  // Arctangent steps in Q.20 degrees
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int DEG_FRAC = 20;
  localparam int ATAN_W = 26;
  localparam logic [CORDIC_STEPS-1:0][ATAN_W-1:0] ATAN_TAB = {
    26'd7, 26'd14, 26'd29, 26'd57, 26'd115, 26'd229, 26'd458, 26'd917,
    26'd1833, 26'd3667, 26'd7334, 26'd14668, 26'd29335, 26'd58671, 26'd117342,
    26'd234682, 26'd469358, 26'd938658, 26'd1876857, 26'd3750058, 26'd7471121,
    26'd14718068, 26'd27855475, 26'd47185920
  };

  typedef logic [HALF_BINS-1:0][TRIG_W-1:0] trig_tab_t;

  // Bin memory control word
  typedef struct packed {
    logic [BIN_AW-1:0] rd_addr;
    logic              wr_en;
    logic [BIN_AW-1:0] wr_addr;
    logic              clear;
  } dirh_mem_ctl_t;

  // Quarter-wave sine, nested series in unsigned Q30
  function automatic logic [63:0] sin_quarter(logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int j = 8; j >= 1; j--) begin
      t = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV[j-1]);
    end
    return (x * t) >> 30;
  endfunction

  // Signed trig value of a turn fraction
  function automatic logic [TRIG_W-1:0] trig_at(logic [63:0] f_in);
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] u;
    logic [63:0] m;
    f = f_in & 64'hFFFF_FFFF;
    q = f >> 30;
    u = f & (Q30_ONE - 64'd1);
    if (q[0]) begin
      u = Q30_ONE - u;
    end
    m = sin_quarter(u);
    m = (m + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    if (q[1]) begin
      m = 64'd0 - m;
    end
    return m[TRIG_W-1:0];
  endfunction

  function automatic trig_tab_t build_trig_tab(logic cos_sel);
    trig_tab_t tab;
    logic [63:0] f;
    for (int i = 0; i < HALF_BINS; i++) begin
      f = (64'(i) << 32) / FULL_BINS;
      tab[i] = trig_at(cos_sel ? f + Q30_ONE : f);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_trig_tab(1'b1);

endpackage

/* design/dirh_bin_mem.sv */
// Direction bin memory; per-entry valid bits let a clear empty it.
module dirh_bin_mem #(
  parameter int DataWidth = dirh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dirh_pkg::dirh_mem_ctl_t ctl_i,
  input  logic [DataWidth-1:0]   wr_data_i,
  output logic [DataWidth-1:0]   rd_data_o
);

  logic [DataWidth-1:0] mem [dirh_pkg::HALF_BINS];
  logic [dirh_pkg::HALF_BINS-1:0] valid_q;
  logic [DataWidth-1:0] rd_data_q;
  logic rd_valid_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= wr_data_i;
    end
    rd_data_q <= mem[ctl_i.rd_addr];
  end

  // Track written entries, drop them all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[ctl_i.rd_addr];
      if (ctl_i.clear) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[ctl_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* design/dirh_cordic.sv */
// Iterative vectoring arctangent of the best resultant, in Q9.7 degrees.
module dirh_cordic #(
  parameter int MagWidth = 34
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [MagWidth-1:0]                 x_mag_i,
  input  logic                                x_neg_i,
  input  logic [MagWidth-1:0]                 y_mag_i,
  input  logic                                y_neg_i,
  output logic                                busy_o,
  output logic signed [dirh_pkg::ANGLE_W-1:0] angle_o
);

  localparam int NW = (MagWidth > 42) ? MagWidth : 42;
  localparam int XW = 45;
  localparam int ZW = 32;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_ROT = 2'd2;
  localparam logic [1:0] ST_END = 2'd3;
  localparam logic signed [ZW-1:0] Z_90 = ZW'(90) <<< dirh_pkg::DEG_FRAC;
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180) <<< dirh_pkg::DEG_FRAC;
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< (dirh_pkg::DEG_FRAC - 8);

  logic [1:0] state_q, state_d;
  logic [NW-1:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [XW-1:0] xs_q, xs_d, ys_q, ys_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [dirh_pkg::STEP_W-1:0] step_q, step_d;
  logic xn_q, xn_d, yn_q, yn_d;
  logic signed [dirh_pkg::ANGLE_W-1:0] angle_q, angle_d;
  logic [NW-1:0] nor_w;
  logic signed [XW-1:0] dx_w, dy_w;
  logic signed [ZW-1:0] at_w, zc_w, r_w;

  assign nor_w = nx_q | ny_q;
  assign dx_w = ys_q >>> step_q;
  assign dy_w = xs_q >>> step_q;
  assign at_w = ZW'(dirh_pkg::ATAN_TAB[step_q]);

  // Clamp, mirror, round and sign the final angle
  always_comb begin
    if (z_q < 0) begin
      zc_w = '0;
    end else if (z_q > Z_90) begin
      zc_w = Z_90;
    end else begin
      zc_w = z_q;
    end
    if (xn_q) begin
      zc_w = Z_180 - zc_w;
    end
    r_w = (zc_w + Z_HALF) >>> (dirh_pkg::DEG_FRAC - 7);
    if (yn_q) begin
      r_w = -r_w;
    end
  end

  // Sequence normalize, rotate, finish
  always_comb begin
    state_d = state_q;
    nx_d = nx_q;
    ny_d = ny_q;
    xs_d = xs_q;
    ys_d = ys_q;
    z_d = z_q;
    step_d = step_q;
    xn_d = xn_q;
    yn_d = yn_q;
    angle_d = angle_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          nx_d = NW'(x_mag_i);
          ny_d = NW'(y_mag_i);
          xn_d = x_neg_i;
          yn_d = y_neg_i;
          if (x_mag_i == '0 && y_mag_i == '0) begin
            angle_d = '0;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if ((nor_w >> 41) != '0) begin
          nx_d = nx_q >> 1;
          ny_d = ny_q >> 1;
        end else if ((nor_w >> 40) == '0) begin
          nx_d = nx_q << 1;
          ny_d = ny_q << 1;
        end else begin
          xs_d = XW'(nx_q[41:0]);
          ys_d = XW'(ny_q[41:0]);
          z_d = '0;
          step_d = '0;
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (ys_q >= 0) begin
          xs_d = xs_q + dx_w;
          ys_d = ys_q - dy_w;
          z_d = z_q + at_w;
        end else begin
          xs_d = xs_q - dx_w;
          ys_d = ys_q + dy_w;
          z_d = z_q - at_w;
        end
        step_d = step_q + 1'b1;
        if (step_q == dirh_pkg::STEP_W'(dirh_pkg::CORDIC_STEPS - 1)) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        angle_d = r_w[dirh_pkg::ANGLE_W-1:0];
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
    ny_q <= ny_d;
    xs_q <= xs_d;
    ys_q <= ys_d;
    z_q <= z_d;
    step_q <= step_d;
    xn_q <= xn_d;
    yn_q <= yn_d;
    angle_q <= angle_d;
  end

  assign busy_o = state_q != ST_IDLE;
  assign angle_o = angle_q;

endmodule

/* design/dirh_isqrt.sv */
// Restoring integer square root of a 64-bit word, two bits per cycle.
module dirh_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic busy_q, busy_d;
  logic [5:0] cnt_q, cnt_d;
  logic [63:0] val_q, val_d;
  logic [35:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [35:0] rem_w, trial_w;

  assign rem_w = {rem_q[33:0], val_q[63:62]};
  assign trial_w = {2'b00, root_q, 2'b01};

  // Take one root bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    val_d = val_q;
    rem_d = rem_q;
    root_d = root_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d = '0;
        val_d = value_i;
        rem_d = '0;
        root_d = '0;
      end
    end else begin
      if (rem_w >= trial_w) begin
        rem_d = rem_w - trial_w;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d = rem_w;
        root_d = {root_q[30:0], 1'b0};
      end
      val_d = val_q << 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    val_q <= val_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* design/dominant_direction_histogram.sv */
// Top level: sample intake, window sweep over the bin memory, result word.
//
// A sample word raises busy for one cycle while the selected bin is read
// from the bin memory and, if the word is counted, written back incremented.
// A word with last set then keeps busy high and runs the estimation: every
// bin is read to form the first window, followed by a drain state; each of
// the 180 sliding windows then passes through read, evaluate, square and
// compare states; then the arctangent unit (normalize steps, 24 rotation
// steps and one rounding step) and the 32-step square root run in parallel,
// and busy stays high until both are done.
// The result word is driven for exactly one cycle with result_valid_o high
// and cannot be held off; it must be taken in that cycle. The histogram and
// sample count are cleared at once when the result word is issued.
module dominant_direction_histogram #(
  parameter int COUNT_WIDTH = dirh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                mean_threshold_we_i,
  input  logic [dirh_pkg::MEAN_W-1:0]         mean_threshold_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [dirh_pkg::DIR_W-1:0]          direction_deg_i,
  input  logic                                direction_missing_i,
  input  logic [dirh_pkg::MEAN_W-1:0]         tile_mean_i,
  input  logic                                last_i,
  output logic                                result_valid_o,
  output logic [dirh_pkg::LEN_W-1:0]          max_length_o,
  output logic signed [dirh_pkg::ANGLE_W-1:0] angle_o,
  output logic [dirh_pkg::TOTAL_W-1:0]        used_samples_o
);

  localparam int AW = dirh_pkg::BIN_AW;
  localparam int TW = dirh_pkg::TRIG_W;
  localparam int SUM_W = COUNT_WIDTH + TW + 8;
  localparam int MAG_W = SUM_W - 7;
  localparam int SQ_W = 2 * MAG_W + 1;
  localparam int PROD_W = COUNT_WIDTH + 1 + TW;
  localparam int RSH = dirh_pkg::TRIG_FRAC_BITS - 8;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (dirh_pkg::TRIG_FRAC_BITS - 9);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [dirh_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_UPD = 4'd1;
  localparam logic [3:0] ST_ACC = 4'd2;
  localparam logic [3:0] ST_ACC_TAIL = 4'd3;
  localparam logic [3:0] ST_WIN_RD = 4'd4;
  localparam logic [3:0] ST_WIN_EV = 4'd5;
  localparam logic [3:0] ST_WIN_SQ = 4'd6;
  localparam logic [3:0] ST_WIN_CMP = 4'd7;
  localparam logic [3:0] ST_FIN = 4'd8;
  localparam logic [3:0] ST_WAIT = 4'd9;

  logic [3:0] state_q, state_d;
  logic [AW-1:0] idx_q, idx_d, rd_idx_q, rd_idx_d, bin_q, bin_d;
  logic rd_vld_q, rd_vld_d;
  logic cnt_en_q, cnt_en_d, last_q, last_d;
  logic [dirh_pkg::MEAN_W-1:0] thr_q;
  logic [dirh_pkg::TOTAL_W-1:0] total_q, total_d;
  logic signed [SUM_W-1:0] sum_c_q, sum_c_d, sum_s_q, sum_s_d;
  logic [MAG_W-1:0] am_q, am_d, bm_q, bm_d, best_am_q, best_am_d, best_bm_q, best_bm_d;
  logic an_q, an_d, bn_q, bn_d, best_an_q, best_an_d, best_bn_q, best_bn_d;
  logic [2*MAG_W-1:0] sqa_q, sqa_d, sqb_q, sqb_d;
  logic [SQ_W-1:0] best_sq_q, best_sq_d;
  logic res_vld_q, res_vld_d;
  logic [dirh_pkg::LEN_W-1:0] len_q, len_d;
  logic signed [dirh_pkg::ANGLE_W-1:0] ang_q, ang_d;
  logic [dirh_pkg::TOTAL_W-1:0] used_q, used_d;

  dirh_pkg::dirh_mem_ctl_t mem_ctl;
  logic [COUNT_WIDTH-1:0] mem_wr_data, mem_rd_data;
  logic [dirh_pkg::DIR_W-1:0] dir_wrap;
  logic accept;
  logic unit_start, cordic_busy, sqrt_busy;
  logic signed [dirh_pkg::ANGLE_W-1:0] cordic_angle;
  logic [31:0] sqrt_root;
  logic [AW-1:0] tr_idx;
  logic signed [TW-1:0] cos_w, sin_w;
  logic signed [PROD_W-1:0] pc_w, ps_w;
  logic [SUM_W-1:0] mag_c_w, mag_s_w, rc_w, rs_w;
  logic [SQ_W-1:0] sq_sum_w;

  assign accept = start && !busy;
  assign dir_wrap = (direction_deg_i >= dirh_pkg::DIR_SPAN) ?
                    direction_deg_i - dirh_pkg::DIR_SPAN : direction_deg_i;

  // Trig lookup and bin products
  assign tr_idx = (state_q == ST_WIN_EV) ? idx_q : rd_idx_q;
  assign cos_w = dirh_pkg::COS_TAB[tr_idx];
  assign sin_w = dirh_pkg::SIN_TAB[tr_idx];
  assign pc_w = $signed({1'b0, mem_rd_data}) * cos_w;
  assign ps_w = $signed({1'b0, mem_rd_data}) * sin_w;

  // Round window sums to Q.8 magnitudes
  assign mag_c_w = sum_c_q[SUM_W-1] ? SUM_W'(-sum_c_q) : SUM_W'(sum_c_q);
  assign mag_s_w = sum_s_q[SUM_W-1] ? SUM_W'(-sum_s_q) : SUM_W'(sum_s_q);
  assign rc_w = (mag_c_w + RND) >> RSH;
  assign rs_w = (mag_s_w + RND) >> RSH;
  assign sq_sum_w = SQ_W'(sqa_q) + SQ_W'(sqb_q);

  // Memory control
  always_comb begin
    mem_ctl = '0;
    unique case (state_q)
      ST_IDLE: mem_ctl.rd_addr = dir_wrap[AW-1:0];
      ST_ACC, ST_WIN_RD: mem_ctl.rd_addr = idx_q;
      default: mem_ctl.rd_addr = '0;
    endcase
    mem_ctl.wr_en = (state_q == ST_UPD) && cnt_en_q;
    mem_ctl.wr_addr = bin_q;
    mem_ctl.clear = (state_q == ST_WAIT) && !cordic_busy && !sqrt_busy;
  end
  assign mem_wr_data = (mem_rd_data == CNT_MAX) ? mem_rd_data : mem_rd_data + 1'b1;
  assign unit_start = state_q == ST_FIN;

  // Sequencer and datapath next values
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    bin_d = bin_q;
    cnt_en_d = cnt_en_q;
    last_d = last_q;
    total_d = total_q;
    sum_c_d = sum_c_q;
    sum_s_d = sum_s_q;
    am_d = am_q;
    an_d = an_q;
    bm_d = bm_q;
    bn_d = bn_q;
    sqa_d = sqa_q;
    sqb_d = sqb_q;
    best_sq_d = best_sq_q;
    best_am_d = best_am_q;
    best_an_d = best_an_q;
    best_bm_d = best_bm_q;
    best_bn_d = best_bn_q;
    res_vld_d = 1'b0;
    len_d = len_q;
    ang_d = ang_q;
    used_d = used_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bin_d = dir_wrap[AW-1:0];
          cnt_en_d = !direction_missing_i && (tile_mean_i >= thr_q);
          last_d = last_i;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cnt_en_q && total_q != TOTAL_MAX) begin
          total_d = total_q + 1'b1;
        end
        rd_vld_d = 1'b0;
        idx_d = '0;
        sum_c_d = '0;
        sum_s_d = '0;
        state_d = last_q ? ST_ACC : ST_IDLE;
      end
      ST_ACC, ST_ACC_TAIL: begin
        if (rd_vld_q) begin
          sum_c_d = sum_c_q + SUM_W'(pc_w);
          sum_s_d = sum_s_q + SUM_W'(ps_w);
        end
        if (state_q == ST_ACC) begin
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q;
          idx_d = idx_q + 1'b1;
          if (idx_q == dirh_pkg::LAST_BIN) begin
            state_d = ST_ACC_TAIL;
          end
        end else begin
          rd_vld_d = 1'b0;
          idx_d = '0;
          best_sq_d = '0;
          best_am_d = '0;
          best_an_d = 1'b0;
          best_bm_d = '0;
          best_bn_d = 1'b0;
          state_d = ST_WIN_RD;
        end
      end
      ST_WIN_RD: state_d = ST_WIN_EV;
      ST_WIN_EV: begin
        am_d = rc_w[MAG_W-1:0];
        bm_d = rs_w[MAG_W-1:0];
        an_d = sum_c_q[SUM_W-1] && (rc_w != '0);
        bn_d = sum_s_q[SUM_W-1] && (rs_w != '0);
        // Slide: the bin leaving the window re-enters at the opposite angle
        sum_c_d = sum_c_q - (SUM_W'(pc_w) <<< 1);
        sum_s_d = sum_s_q - (SUM_W'(ps_w) <<< 1);
        state_d = ST_WIN_SQ;
      end
      ST_WIN_SQ: begin
        sqa_d = am_q * am_q;
        sqb_d = bm_q * bm_q;
        state_d = ST_WIN_CMP;
      end
      ST_WIN_CMP: begin
        if (sq_sum_w > best_sq_q) begin
          best_sq_d = sq_sum_w;
          best_am_d = am_q;
          best_an_d = an_q;
          best_bm_d = bm_q;
          best_bn_d = bn_q;
        end
        idx_d = idx_q + 1'b1;
        state_d = (idx_q == dirh_pkg::LAST_BIN) ? ST_FIN : ST_WIN_RD;
      end
      ST_FIN: state_d = ST_WAIT;
      ST_WAIT: begin
        if (!cordic_busy && !sqrt_busy) begin
          len_d = ((best_sq_q >> 64) != '0) ? '1 : sqrt_root;
          ang_d = cordic_angle;
          used_d = total_q;
          res_vld_d = 1'b1;
          total_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      total_q <= '0;
      res_vld_q <= 1'b0;
      thr_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      rd_vld_q <= rd_vld_d;
      total_q <= total_d;
      res_vld_q <= res_vld_d;
      if (mean_threshold_we_i) begin
        thr_q <= mean_threshold_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    bin_q <= bin_d;
    cnt_en_q <= cnt_en_d;
    last_q <= last_d;
    sum_c_q <= sum_c_d;
    sum_s_q <= sum_s_d;
    am_q <= am_d;
    an_q <= an_d;
    bm_q <= bm_d;
    bn_q <= bn_d;
    sqa_q <= sqa_d;
    sqb_q <= sqb_d;
    best_sq_q <= best_sq_d;
    best_am_q <= best_am_d;
    best_an_q <= best_an_d;
    best_bm_q <= best_bm_d;
    best_bn_q <= best_bn_d;
    len_q <= len_d;
    ang_q <= ang_d;
    used_q <= used_d;
  end

  dirh_bin_mem #(
    .DataWidth(COUNT_WIDTH)
  ) u_bin_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .wr_data_i(mem_wr_data),
    .rd_data_o(mem_rd_data)
  );

  dirh_cordic #(
    .MagWidth(MAG_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .x_mag_i (best_am_q),
    .x_neg_i (best_an_q),
    .y_mag_i (best_bm_q),
    .y_neg_i (best_bn_q),
    .busy_o  (cordic_busy),
    .angle_o (cordic_angle)
  );

  dirh_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(unit_start),
    .value_i(best_sq_q[63:0]),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  assign busy = state_q != ST_IDLE;
  assign result_valid_o = res_vld_q;
  assign max_length_o = len_q;
  assign angle_o = ang_q;
  assign used_samples_o = used_q;

endmodule

/* sim/dominant_direction_histogram_test.sv */
// Self-checking testbench for the dominant direction histogram block.
`timescale 1ns / 1ps

module dominant_direction_histogram_test;

  localparam int DIR_W = dirh_pkg::DIR_W;
  localparam int MEAN_W = dirh_pkg::MEAN_W;
  localparam int LEN_W = dirh_pkg::LEN_W;
  localparam int ANGLE_W = dirh_pkg::ANGLE_W;
  localparam int TOTAL_W = dirh_pkg::TOTAL_W;
  localparam int HALF_BINS = dirh_pkg::HALF_BINS;
  localparam int FULL_BINS = dirh_pkg::FULL_BINS;
  localparam int CORDIC_STEPS = dirh_pkg::CORDIC_STEPS;
  localparam int TRIG_FRAC_BITS = dirh_pkg::TRIG_FRAC_BITS;
  localparam int DEG_FRAC = dirh_pkg::DEG_FRAC;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1100;
  localparam int RAND_WORDS = 1800;
  localparam int PHASES = 5;

  typedef struct {
    logic [DIR_W-1:0]  dir;
    logic              missing;
    logic [MEAN_W-1:0] mean;
    logic              last;
    logic              typed;
  } stim_row_t;

  typedef struct {
    logic [LEN_W-1:0]          len;
    logic signed [ANGLE_W-1:0] angle;
    logic [TOTAL_W-1:0]        used;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic mean_threshold_we_i = 1'b0;
  logic [MEAN_W-1:0] mean_threshold_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [DIR_W-1:0] direction_deg_i = '0;
  logic direction_missing_i = 1'b0;
  logic [MEAN_W-1:0] tile_mean_i = '0;
  logic last_i = 1'b0;
  logic result_valid_o;
  logic [LEN_W-1:0] max_length_o;
  logic signed [ANGLE_W-1:0] angle_o;
  logic [TOTAL_W-1:0] used_samples_o;

  dominant_direction_histogram dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .mean_threshold_we_i(mean_threshold_we_i), .mean_threshold_i(mean_threshold_i),
    .start(start), .busy(busy),
    .direction_deg_i(direction_deg_i), .direction_missing_i(direction_missing_i),
    .tile_mean_i(tile_mean_i), .last_i(last_i),
    .result_valid_o(result_valid_o), .max_length_o(max_length_o),
    .angle_o(angle_o), .used_samples_o(used_samples_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  longint sin_q[FULL_BINS];
  longint cos_q[FULL_BINS];
  longint atan_q20[CORDIC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469358,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};
  int unsigned hist[HALF_BINS];
  int unsigned counted;
  logic [MEAN_W-1:0] thresh_model;
  estimate_t estimate_q[$];

  logic typed_word = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  // Quarter-wave sine in unsigned Q30, nested series
  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned x, x2, t;
    x = (u * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int j = 8; j >= 1; j--) begin
      t = (64'd1 << 30) - (((x2 * t) >> 30) / longint'((2 * j) * (2 * j + 1)));
    end
    return (x * t) >> 30;
  endfunction

  function automatic longint turn_trig(longint unsigned f);
    longint unsigned q, u, m;
    f = f & 64'hFFFF_FFFF;
    q = f >> 30;
    u = f & ((64'd1 << 30) - 1);
    if (q[0]) begin
      u = (64'd1 << 30) - u;
    end
    m = quarter_sine(u);
    m = (m + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return q[1] ? -longint'(m) : longint'(m);
  endfunction

  // Magnitude rounded half up to Q.8
  function automatic longint unsigned mag_q8(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return (m + (64'd1 << (TRIG_FRAC_BITS - 9))) >> (TRIG_FRAC_BITS - 8);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int vector_angle(longint unsigned am, bit aneg,
                                      longint unsigned bm, bit bneg);
    longint unsigned x, y;
    longint xs, ys, z, dx, dy, r;
    x = am;
    y = bm;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (((x | y) >> 41) != 0) begin
      x = x >> 1;
      y = y >> 1;
    end
    while (((x | y) >> 40) == 0) begin
      x = x << 1;
      y = y << 1;
    end
    xs = x;
    ys = y;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx;
        ys -= dy;
        z += atan_q20[i];
      end else begin
        xs -= dx;
        ys += dy;
        z -= atan_q20[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << DEG_FRAC)) z = longint'(90) << DEG_FRAC;
    if (aneg) z = (longint'(180) << DEG_FRAC) - z;
    r = (z + (1 << (DEG_FRAC - 8))) >>> (DEG_FRAC - 7);
    return bneg ? -int'(r) : int'(r);
  endfunction

  // Sweep all windows over the mirrored histogram and keep the strongest
  function automatic estimate_t sweep_windows();
    estimate_t e;
    longint c, s, v;
    longint unsigned am, bm;
    logic [127:0] sq, best_sq;
    int best_ang, d;
    best_sq = '0;
    best_ang = 0;
    for (int i = 0; i < HALF_BINS; i++) begin
      c = 0;
      s = 0;
      for (int k = 0; k < HALF_BINS; k++) begin
        d = i + k;
        v = hist[d < HALF_BINS ? d : d - HALF_BINS];
        c += v * cos_q[d];
        s += v * sin_q[d];
      end
      am = mag_q8(c);
      bm = mag_q8(s);
      sq = 128'(am) * 128'(am) + 128'(bm) * 128'(bm);
      if (sq > best_sq) begin
        best_sq = sq;
        best_ang = vector_angle(am, c < 0 && am != 0, bm, s < 0 && bm != 0);
      end
    end
    e.len = (best_sq[127:64] != 0) ? '1 : LEN_W'(int_sqrt(best_sq[63:0]));
    e.angle = ANGLE_W'(best_ang);
    e.used = counted;
    return e;
  endfunction

  function automatic void count_word(logic [DIR_W-1:0] dir, logic miss,
                                     logic [MEAN_W-1:0] mean, logic lst,
                                     logic typed);
    int unsigned b;
    estimate_t e;
    b = (dir >= 180) ? dir - 180 : dir;
    if (!miss && mean >= thresh_model) begin
      if (hist[b] < 16'hFFFF) hist[b]++;
      if (counted != 32'hFFFF_FFFF) counted++;
    end
    if (lst) begin
      // typed rows only cover empty sets: zero length, zero angle
      if (typed) begin
        e.len = '0;
        e.angle = '0;
        e.used = '0;
      end else begin
        e = sweep_windows();
      end
      estimate_q.push_back(e);
      foreach (hist[i]) hist[i] = 0;
      counted = 0;
    end
  endfunction

  // Accept words, check results, watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (mean_threshold_we_i) thresh_model = mean_threshold_i;
      if (result_valid_o) begin
        if (estimate_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: len %0d angle %0d used %0d",
                                     max_length_o, angle_o, used_samples_o);
        end else begin
          estimate_t e;
          e = estimate_q.pop_front();
          if (e.len !== max_length_o || e.angle !== angle_o || e.used !== used_samples_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp len %0d angle %0d used %0d, got len %0d angle %0d used %0d",
                       e.len, e.angle, e.used, max_length_o, angle_o, used_samples_o);
          end
        end
      end
      if (start && !busy) begin
        count_word(direction_deg_i, direction_missing_i, tile_mean_i, last_i, typed_word);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(logic [DIR_W-1:0] dir, logic miss, logic [MEAN_W-1:0] mean,
                           logic lst, logic typed);
    @(negedge clk_i);
    start <= 1'b1;
    direction_deg_i <= dir;
    direction_missing_i <= miss;
    tile_mean_i <= mean;
    last_i <= lst;
    typed_word <= typed;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drain, let the block settle, then write the threshold
  task automatic set_threshold(logic [MEAN_W-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    mean_threshold_we_i <= 1'b1;
    mean_threshold_i <= value;
    @(negedge clk_i);
    mean_threshold_we_i <= 1'b0;
  endtask

  stim_row_t directed[] = '{
    '{8'd0, 1'b0, 24'd0, 1'b1, 1'b0},
    '{8'd40, 1'b1, 24'hFFFFFF, 1'b1, 1'b1},
    '{8'd0, 1'b0, 24'd0, 1'b1, 1'b0},
    '{8'd90, 1'b0, 24'd1, 1'b1, 1'b0},
    '{8'd179, 1'b0, 24'hFFFFFF, 1'b0, 1'b0},
    '{8'd180, 1'b0, 24'h800000, 1'b0, 1'b0},
    '{8'd255, 1'b0, 24'h7FFFFF, 1'b1, 1'b0},
    '{8'd0, 1'b0, 24'd5, 1'b0, 1'b0},
    '{8'd0, 1'b0, 24'd5, 1'b0, 1'b0},
    '{8'd90, 1'b0, 24'd5, 1'b0, 1'b0},
    '{8'd90, 1'b0, 24'd5, 1'b1, 1'b0},
    '{8'd45, 1'b0, 24'd9, 1'b0, 1'b0},
    '{8'd135, 1'b0, 24'd9, 1'b0, 1'b0},
    '{8'd170, 1'b0, 24'd9, 1'b1, 1'b0},
    '{8'd1, 1'b0, 24'd3, 1'b0, 1'b0},
    '{8'd181, 1'b1, 24'd3, 1'b1, 1'b0}
  };

  initial begin
    logic [MEAN_W-1:0] thr;
    logic [DIR_W-1:0] center, dir;
    logic [MEAN_W-1:0] mean;
    int gap_pct;
    for (int i = 0; i < FULL_BINS; i++) begin
      longint unsigned f;
      f = (longint'(i) << 32) / FULL_BINS;
      sin_q[i] = turn_trig(f);
      cos_q[i] = turn_trig(f + (64'd1 << 30));
    end
    foreach (hist[i]) hist[i] = 0;
    counted = 0;
    thresh_model = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at threshold zero
    foreach (directed[i])
      send_word(directed[i].dir, directed[i].missing, directed[i].mean,
                directed[i].last, directed[i].typed);
    // Threshold at its top: only a full-scale mean counts
    set_threshold('1);
    send_word(8'd10, 1'b0, 24'hFFFFFE, 1'b0, 1'b0);
    send_word(8'd20, 1'b0, 24'hFFFFFF, 1'b1, 1'b0);

    // Random phases over thresholds and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = '0;
        1: thr = '1;
        2: thr = 24'h800000;
        default: thr = MEAN_W'($urandom);
      endcase
      set_threshold(thr);
      case (p % 4)
        1: gap_pct = 75;
        3: gap_pct = 10;
        default: gap_pct = 0;
      endcase
      center = DIR_W'($urandom_range(0, 179));
      for (int n = 0; n < RAND_WORDS / PHASES; n++) begin
        if ($urandom_range(0, 99) < 50)
          dir = DIR_W'((center + $urandom_range(0, 40) + 160) % 180);
        else
          dir = DIR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: mean = MEAN_W'($urandom);
          1: mean = thr;
          2: mean = (thr == 0) ? thr : thr - MEAN_W'(1);
          default: mean = '1;
        endcase
        send_word(dir, $urandom_range(0, 9) == 0, mean, $urandom_range(0, 29) == 0, 1'b0);
        if ($urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 8));
      end
      send_word(center, 1'b0, '1, 1'b1, 1'b0);
    end

    // Drain and finish
    @(negedge clk_i);
    start <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
